### hw/rtl/mfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfs_pkg
// Types, constants and helpers shared by the motor fault supervisor.
// ----------------------------------------------------------------------------
package mfs_pkg;

  localparam int NUM_MON     = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0]        OC_HYSTERESIS     = 16'd50;
  localparam logic signed [13:0] TEMP_HYST         = 14'sd50;
  localparam logic [31:0]        STALL_CMD_THRESH  = 32'd200;
  localparam logic [7:0]         STALL_RATIO_Q8    = 8'd26;
  localparam logic [15:0]        STALL_HOLD_TIME   = 16'd1000;
  localparam logic [31:0]        MIN_CMD_FLOOR     = 32'd100;

  // monitor order
  localparam int MON_OC1   = 0;
  localparam int MON_OC2   = 1;
  localparam int MON_T1    = 2;
  localparam int MON_T2    = 3;
  localparam int MON_RUN   = 4;
  localparam int MON_STALL = 5;

  typedef enum logic [2:0] {
    CFG_ENABLE         = 3'd0,
    CFG_OC_LIMIT_M1    = 3'd1,
    CFG_OC_LIMIT_M2    = 3'd2,
    CFG_OC_DETECT_TIME = 3'd3,
    CFG_TEMP_LIM1      = 3'd4,
    CFG_TEMP_LIM2      = 3'd5,
    CFG_RUNAWAY_FACTOR = 3'd6,
    CFG_RUNAWAY_TIME   = 3'd7
  } cfg_index_t;

  typedef enum logic [2:0] {
    FS_NONE    = 3'd0,
    FS_OC_M1   = 3'd1,
    FS_OC_M2   = 3'd2,
    FS_TEMP1   = 3'd3,
    FS_TEMP2   = 3'd4,
    FS_RUNAWAY = 3'd5,
    FS_STALL   = 3'd6
  } fault_src_t;

  typedef struct packed {
    logic [31:0]        stamp_ms;
    logic [15:0]        cur_m1;
    logic [15:0]        cur_m2;
    logic signed [11:0] temp1;
    logic signed [11:0] temp2;
    logic signed [31:0] m1_cmd_speed;
    logic signed [31:0] m2_cmd_speed;
    logic signed [31:0] m1_meas_speed;
    logic signed [31:0] m2_meas_speed;
  } in_t;

  typedef struct packed {
    logic       estop;
    logic [2:0] fault_source;
  } out_t;

  typedef struct packed {
    logic               enable;
    logic [15:0]        oc_limit_m1;
    logic [15:0]        oc_limit_m2;
    logic [15:0]        oc_detect_time;
    logic signed [11:0] temp_lim1;
    logic signed [11:0] temp_lim2;
    logic [15:0]        runaway_factor;
    logic [15:0]        runaway_hold_ms;
  } cfg_t;

  // classified sample: per monitor, condition holds / disarm condition holds
  typedef struct packed {
    logic [31:0]        stamp_ms;
    logic [NUM_MON-1:0] cond;
    logic [NUM_MON-1:0] clr;
  } mon_rec_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

### hw/rtl/mfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfs_front
// Accepts samples and classifies them into per-monitor condition flags.
// ----------------------------------------------------------------------------
module mfs_front import mfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_t      in_data,
  output logic     push,
  output mon_rec_t push_rec,
  input  logic     q_full
);

  typedef struct packed {
    logic [31:0] stamp_ms;
    logic [3:0]  cond;
    logic [3:0]  clr;
    logic [31:0] cmd;
    logic [31:0] meas;
    logic [31:0] base;
  } s1_t;

  logic s1_valid_r, s1_valid_nxt;
  s1_t  s1_r, s1_nxt;

  logic [31:0] c1, c2, m1, m2;
  logic [47:0] run_prod;
  logic [39:0] stall_prod;
  logic        run_cond, stall_cond;

  assign in_ready = !s1_valid_r || !q_full;
  assign push     = s1_valid_r && !q_full;

  always_comb begin
    c1 = mag32(in_data.m1_cmd_speed);
    c2 = mag32(in_data.m2_cmd_speed);
    m1 = mag32(in_data.m1_meas_speed);
    m2 = mag32(in_data.m2_meas_speed);

    s1_nxt.stamp_ms = in_data.stamp_ms;
    s1_nxt.cmd      = (c1 > c2) ? c1 : c2;
    s1_nxt.meas     = (m1 > m2) ? m1 : m2;
    s1_nxt.base     = (s1_nxt.cmd > MIN_CMD_FLOOR) ? s1_nxt.cmd : MIN_CMD_FLOOR;

    s1_nxt.cond[MON_OC1] = in_data.cur_m1 > cfg.oc_limit_m1;
    s1_nxt.cond[MON_OC2] = in_data.cur_m2 > cfg.oc_limit_m2;
    s1_nxt.clr[MON_OC1]  = ({2'b00, in_data.cur_m1} + {2'b00, OC_HYSTERESIS})
                           < {2'b00, cfg.oc_limit_m1};
    s1_nxt.clr[MON_OC2]  = ({2'b00, in_data.cur_m2} + {2'b00, OC_HYSTERESIS})
                           < {2'b00, cfg.oc_limit_m2};

    s1_nxt.cond[MON_T1] = in_data.temp1 > cfg.temp_lim1;
    s1_nxt.cond[MON_T2] = in_data.temp2 > cfg.temp_lim2;
    s1_nxt.clr[MON_T1]  = (14'(in_data.temp1) + TEMP_HYST) < 14'(cfg.temp_lim1);
    s1_nxt.clr[MON_T2]  = (14'(in_data.temp2) + TEMP_HYST) < 14'(cfg.temp_lim2);
  end

  always_comb begin
    run_prod   = {32'd0, cfg.runaway_factor} * {16'd0, s1_r.base};
    stall_prod = {8'd0, s1_r.cmd} * {32'd0, STALL_RATIO_Q8};
    run_cond   = {8'd0, s1_r.meas} > run_prod[47:8];
    stall_cond = (s1_r.cmd > STALL_CMD_THRESH) && (s1_r.meas < stall_prod[39:8]);

    push_rec.stamp_ms = s1_r.stamp_ms;
    push_rec.cond     = {stall_cond, run_cond, s1_r.cond};
    push_rec.clr      = {!stall_cond, !run_cond, s1_r.clr};
  end

  assign s1_valid_nxt = in_ready ? in_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_ready && in_valid) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

### hw/rtl/mfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfs_queue
// Short register queue of classified samples between front and back.
// ----------------------------------------------------------------------------
module mfs_queue import mfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  mon_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     q_valid,
  output mon_rec_t q_rec
);

  mon_rec_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

### hw/rtl/mfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfs_back
// Applies classified samples to the monitor state and registers the result.
// ----------------------------------------------------------------------------
module mfs_back import mfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  mon_rec_t q_rec,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output out_t     out_data
);

  logic [NUM_MON-1:0] armed_r, armed_nxt;
  logic [31:0]        since_r [NUM_MON];
  logic [31:0]        since_nxt [NUM_MON];
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic [31:0]        el [NUM_MON];
  logic [NUM_MON-1:0] due, trip, first_oh, active;
  logic               found;
  logic [2:0]         src;

  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    for (int k = 0; k < NUM_MON; k++) begin
      el[k] = q_rec.stamp_ms - since_r[k];
    end
    due[MON_OC1]   = el[MON_OC1] >= {16'd0, cfg.oc_detect_time};
    due[MON_OC2]   = el[MON_OC2] >= {16'd0, cfg.oc_detect_time};
    due[MON_T1]    = el[MON_T1] != 32'd0;
    due[MON_T2]    = el[MON_T2] != 32'd0;
    due[MON_RUN]   = el[MON_RUN] >= {16'd0, cfg.runaway_hold_ms};
    due[MON_STALL] = el[MON_STALL] >= {16'd0, STALL_HOLD_TIME};
    trip = q_rec.cond & armed_r & due;

    found    = 1'b0;
    src      = FS_NONE;
    first_oh = '0;
    active   = '0;
    for (int k = 0; k < NUM_MON; k++) begin
      active[k] = !found;
      if (!found && trip[k]) begin
        found       = 1'b1;
        first_oh[k] = 1'b1;
        src         = 3'(k + 1);
      end
    end

    armed_nxt = armed_r;
    for (int k = 0; k < NUM_MON; k++) begin
      since_nxt[k] = since_r[k];
      if (pop && cfg.enable && active[k] && !trip[k]) begin
        if (q_rec.cond[k] && !armed_r[k]) begin
          armed_nxt[k] = 1'b1;
          since_nxt[k] = q_rec.stamp_ms;
        end else if (!q_rec.cond[k] && q_rec.clr[k]) begin
          armed_nxt[k] = 1'b0;
        end
      end
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (pop) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.estop        = cfg.enable && found;
      out_data_nxt.fault_source = cfg.enable ? src : FS_NONE;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    for (int k = 0; k < NUM_MON; k++) begin
      since_r[k] <= since_nxt[k];
    end
    out_data_r <= out_data_nxt;
  end

  a_estop_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.estop == (out_data_r.fault_source != FS_NONE)))
    else $error("estop and fault_source disagree");

  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first_oh))
    else $error("more than one first trip");

  a_trip_stays_armed: assert property (@(posedge clk) disable iff (!rst_n)
    pop && cfg.enable && found |=> (armed_r & $past(first_oh)) != '0)
    else $error("tripped monitor lost its armed bit");

  a_disabled_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !cfg.enable |=> $stable(armed_r) && !out_data_r.estop)
    else $error("state changed while disabled");

endmodule

### hw/rtl/motor_fault_supervisor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_fault_supervisor
// Six persistence monitors on motor telemetry giving estop and fault source.
// ----------------------------------------------------------------------------
// One sample is accepted and one result leaves per clock while out_ready is
// high; a result passes the front register, a queue entry and the back's
// output register. The front registers current and temperature compares and
// the speed magnitudes, then forms the runaway product and stall test; a
// four-entry queue decouples it from the back, whose monitor state update
// sets that rate. Configuration registers are written through cfg_valid /
// cfg_ready, which is always ready, and should only be written while idle.
// ----------------------------------------------------------------------------
module motor_fault_supervisor import mfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  logic     push, q_full, q_valid, pop;
  mon_rec_t push_rec, q_rec;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_ENABLE:         cfg_nxt.enable          = cfg_data[0];
        CFG_OC_LIMIT_M1:    cfg_nxt.oc_limit_m1     = cfg_data;
        CFG_OC_LIMIT_M2:    cfg_nxt.oc_limit_m2     = cfg_data;
        CFG_OC_DETECT_TIME: cfg_nxt.oc_detect_time  = cfg_data;
        CFG_TEMP_LIM1:      cfg_nxt.temp_lim1       = cfg_data[11:0];
        CFG_TEMP_LIM2:      cfg_nxt.temp_lim2       = cfg_data[11:0];
        CFG_RUNAWAY_FACTOR: cfg_nxt.runaway_factor  = cfg_data;
        CFG_RUNAWAY_TIME:   cfg_nxt.runaway_hold_ms = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable          <= 1'b1;
      cfg_r.oc_limit_m1     <= 16'd1000;
      cfg_r.oc_limit_m2     <= 16'd1000;
      cfg_r.oc_detect_time  <= 16'd500;
      cfg_r.temp_lim1       <= 12'sd850;
      cfg_r.temp_lim2       <= 12'sd850;
      cfg_r.runaway_factor  <= 16'd512;
      cfg_r.runaway_hold_ms <= 16'd500;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mfs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .push_rec (push_rec),
    .q_full   (q_full)
  );

  mfs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_rec    (q_rec)
  );

  mfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
